/* design/rdse_pkg.sv */
package rdse_pkg;

   // Width of the shared compare-and-subtract unit. A fraction times the base
   // stays below sixteen million, which fits in 24 bits.
   localparam int UNIT_W = 24;

   localparam logic [UNIT_W-1:0] ONE_MILLION  = 24'd1000000;
   localparam logic [19:0]       FRAC_MAX     = 20'd999999;
   localparam logic [4:0]        RADIX_MIN    = 5'd2;
   localparam logic [4:0]        RADIX_MAX    = 5'd16;
   localparam logic [4:0]        RADIX_RESET  = 5'd10;
   localparam logic [3:0]        FDIG_RESET   = 4'd0;
   localparam logic [5:0]        LAST_SLOT    = 6'd31;

   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_NINE  = 7'h39;
   localparam logic [6:0] CHAR_A     = 7'h41;
   localparam logic [6:0] CHAR_F     = 7'h46;
   localparam logic [6:0] CHAR_POINT = 7'h2E;

   localparam logic CSR_RADIX           = 1'b0;
   localparam logic CSR_FRACTION_DIGITS = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT_INT,
      ST_DOT,
      ST_MUL,
      ST_FSTEP,
      ST_FEMIT
   } state_type;

   typedef struct packed {
      logic              ge;
      logic [UNIT_W-1:0] rest;
   } step_type;

   function automatic logic [6:0] digit_char(input logic [3:0] d);
      logic [6:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + {3'b000, d};
      end else begin
         c = CHAR_A + {3'b000, d} - 7'd10;
      end
      return c;
   endfunction

endpackage

/* design/rdse_req_if.sv */
interface rdse_req_if #(
   parameter int INT_BITS = 16
);
   logic                valid;
   logic                ready;
   logic [INT_BITS-1:0] integer_part;
   logic [19:0]         fraction_millionths;

   modport source (output valid, output integer_part, output fraction_millionths,
                   input ready);
   modport sink   (input valid, input integer_part, input fraction_millionths,
                   output ready);
endinterface

/* design/rdse_rsp_if.sv */
interface rdse_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

/* design/rdse_step_unit.sv */
module rdse_step_unit (
   input  logic [rdse_pkg::UNIT_W-1:0] a,
   input  logic [rdse_pkg::UNIT_W-1:0] b,
   output rdse_pkg::step_type          result
);

   logic [rdse_pkg::UNIT_W:0] diff;

   // One restoring step: subtract when the divisor fits, keep the value otherwise.
   assign diff        = {1'b0, a} - {1'b0, b};
   assign result.ge   = ~diff[rdse_pkg::UNIT_W];
   assign result.rest = diff[rdse_pkg::UNIT_W] ? a : diff[rdse_pkg::UNIT_W-1:0];

endmodule

/* design/radix_digit_string_emitter.sv */
// Channel  Dir  Handshake              Payload
// req      in   req.valid/req.ready    integer_part, fraction_millionths
// rsp      out  rsp.valid/rsp.ready    character, last
// csr      in   csr_we (no wait)       csr_index, csr_wdata
//
// A request is taken in the idle state, then each integer digit is found by bit-serial restoring
// division on the shared compare-and-subtract unit, followed by an emit for each digit.
// With fraction digits on, the point is emitted and each fraction digit takes a multiply by the
// base, four compare-and-subtract steps against eight, four, two and one million, and the emit.
// The block is not ready while a conversion runs; a stalled rsp channel holds the sequencer
// at its next emit and never loses a character. Reset is synchronous and active high.
module radix_digit_string_emitter #(
   parameter int INT_BITS            = 16,
   parameter int MAX_FRACTION_DIGITS = 15
) (
   input  logic        clock,
   input  logic        reset,
   rdse_req_if.sink    req,
   rdse_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [4:0]  csr_wdata
);

   localparam int CNT_W   = $clog2(INT_BITS);
   localparam int DEPTH_W = $clog2(INT_BITS + 1);
   localparam int FD_W    = $clog2(MAX_FRACTION_DIGITS + 1);
   localparam int STACK_W = 4 * INT_BITS;
   localparam int UW      = rdse_pkg::UNIT_W;

   rdse_pkg::state_type state_ff, state_in;

   logic [4:0]          radix_ff, radix_in;
   logic [3:0]          fdig_ff, fdig_in;

   logic [INT_BITS-1:0] y_ff, y_in;
   logic [UW-1:0]       acc_ff, acc_in;
   logic [19:0]         frac_ff, frac_in;
   logic [4:0]          base_ff, base_in;
   logic [FD_W-1:0]     fd_left_ff, fd_left_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [STACK_W-1:0]  stack_ff, stack_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [5:0]          n_ff, n_in;
   logic [3:0]          digit_ff, digit_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [6:0]          rsp_char_ff, rsp_char_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [UW-1:0]       unit_a, unit_b;
   rdse_pkg::step_type  unit_out;

   logic                slot_free;
   logic                emit;
   logic [6:0]          emit_char;
   logic                emit_last;
   logic [FD_W-1:0]     fd_req;

   rdse_step_unit u_step (
      .a      (unit_a),
      .b      (unit_b),
      .result (unit_out)
   );

   assign req.ready     = (state_ff == rdse_pkg::ST_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.character = rsp_char_ff;
   assign rsp.last      = rsp_last_ff;

   // The output register frees up either when empty or when its character leaves.
   assign slot_free = ~rsp_valid_ff | rsp.ready;

   // Requested fraction length, limited to what the block is built for.
   always_comb begin
      if (32'(fdig_ff) > MAX_FRACTION_DIGITS) begin
         fd_req = FD_W'(MAX_FRACTION_DIGITS);
      end else begin
         fd_req = FD_W'(fdig_ff);
      end
   end

   // Configuration writes.
   always_comb begin
      radix_in = radix_ff;
      fdig_in  = fdig_ff;
      if (csr_we) begin
         unique case (csr_index)
            rdse_pkg::CSR_RADIX:           radix_in = csr_wdata;
            rdse_pkg::CSR_FRACTION_DIGITS: fdig_in  = csr_wdata[3:0];
            default:                       radix_in = radix_ff;
         endcase
      end
   end

   // Sequencer: next state, datapath updates and the character to emit.
   always_comb begin
      state_in   = state_ff;
      y_in       = y_ff;
      acc_in     = acc_ff;
      frac_in    = frac_ff;
      base_in    = base_ff;
      fd_left_in = fd_left_ff;
      cnt_in     = cnt_ff;
      stack_in   = stack_ff;
      depth_in   = depth_ff;
      n_in       = n_ff;
      digit_in   = digit_ff;
      unit_a     = '0;
      unit_b     = '0;
      emit       = 1'b0;
      emit_char  = rdse_pkg::CHAR_ZERO;
      emit_last  = 1'b0;

      unique case (state_ff)
         rdse_pkg::ST_IDLE: begin
            if (req.valid) begin
               y_in = req.integer_part;
               if (req.fraction_millionths > rdse_pkg::FRAC_MAX) begin
                  frac_in = rdse_pkg::FRAC_MAX;
               end else begin
                  frac_in = req.fraction_millionths;
               end
               if (radix_ff < rdse_pkg::RADIX_MIN) begin
                  base_in = rdse_pkg::RADIX_MIN;
               end else if (radix_ff > rdse_pkg::RADIX_MAX) begin
                  base_in = rdse_pkg::RADIX_MAX;
               end else begin
                  base_in = radix_ff;
               end
               fd_left_in = fd_req;
               acc_in     = '0;
               cnt_in     = CNT_W'(INT_BITS - 1);
               depth_in   = '0;
               n_in       = '0;
               state_in   = rdse_pkg::ST_DIV;
            end
         end

         rdse_pkg::ST_DIV: begin
            // Shift the next dividend bit into the remainder and try the base.
            // A zero integer part yields one zero digit on its own.
            unit_a = UW'({acc_ff[4:0], y_ff[INT_BITS-1]});
            unit_b = UW'(base_ff);
            acc_in = unit_out.rest;
            y_in   = {y_ff[INT_BITS-2:0], unit_out.ge};
            if (cnt_ff == '0) begin
               // The remainder is the digit; the newest digit sits on top.
               stack_in = {stack_ff[STACK_W-5:0], unit_out.rest[3:0]};
               depth_in = depth_ff + DEPTH_W'(1);
               acc_in   = '0;
               cnt_in   = CNT_W'(INT_BITS - 1);
               if (y_in == '0) begin
                  state_in = rdse_pkg::ST_EMIT_INT;
               end
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end

         rdse_pkg::ST_EMIT_INT: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_char = rdse_pkg::digit_char(stack_ff[3:0]);
               emit_last = (n_ff == rdse_pkg::LAST_SLOT) ||
                           ((depth_ff == DEPTH_W'(1)) && (fd_left_ff == '0));
               stack_in  = {4'b0000, stack_ff[STACK_W-1:4]};
               depth_in  = depth_ff - DEPTH_W'(1);
               n_in      = n_ff + 6'd1;
               if (emit_last) begin
                  state_in = rdse_pkg::ST_IDLE;
               end else if (depth_ff == DEPTH_W'(1)) begin
                  state_in = rdse_pkg::ST_DOT;
               end
            end
         end

         rdse_pkg::ST_DOT: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_char = rdse_pkg::CHAR_POINT;
               emit_last = (n_ff == rdse_pkg::LAST_SLOT);
               n_in      = n_ff + 6'd1;
               state_in  = emit_last ? rdse_pkg::ST_IDLE : rdse_pkg::ST_MUL;
            end
         end

         rdse_pkg::ST_MUL: begin
            acc_in   = UW'({4'b0000, frac_ff}) * UW'(base_ff);
            cnt_in   = CNT_W'(3);
            digit_in = '0;
            state_in = rdse_pkg::ST_FSTEP;
         end

         rdse_pkg::ST_FSTEP: begin
            // Digit bits from eight million down to one million.
            unit_a   = acc_ff;
            unit_b   = rdse_pkg::ONE_MILLION << cnt_ff[1:0];
            acc_in   = unit_out.rest;
            digit_in = {digit_ff[2:0], unit_out.ge};
            if (cnt_ff == '0) begin
               state_in = rdse_pkg::ST_FEMIT;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end

         rdse_pkg::ST_FEMIT: begin
            if (slot_free) begin
               emit       = 1'b1;
               emit_char  = rdse_pkg::digit_char(digit_ff);
               emit_last  = (fd_left_ff == FD_W'(1)) || (n_ff == rdse_pkg::LAST_SLOT);
               frac_in    = acc_ff[19:0];
               fd_left_in = fd_left_ff - FD_W'(1);
               n_in       = n_ff + 6'd1;
               state_in   = emit_last ? rdse_pkg::ST_IDLE : rdse_pkg::ST_MUL;
            end
         end

         default: begin
            state_in = rdse_pkg::ST_IDLE;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rdse_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         radix_ff     <= rdse_pkg::RADIX_RESET;
         fdig_ff      <= rdse_pkg::FDIG_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         radix_ff     <= radix_in;
         fdig_ff      <= fdig_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff        <= y_in;
      acc_ff      <= acc_in;
      frac_ff     <= frac_in;
      base_ff     <= base_in;
      fd_left_ff  <= fd_left_in;
      cnt_ff      <= cnt_in;
      stack_ff    <= stack_in;
      depth_ff    <= depth_in;
      n_ff        <= n_in;
      digit_ff    <= digit_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

/* design/rdse_check.sv */
module rdse_check (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_character,
   input logic       rsp_last
);

   // Nothing is offered on the result side right after reset.
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result keeps its character and marker.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("stalled result changed");

   // The block is busy once it has taken a request, while the conversion runs.
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a conversion is running");

   // Only digits, A to F and the point are ever emitted.
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_character >= rdse_pkg::CHAR_ZERO && rsp_character <= rdse_pkg::CHAR_NINE) ||
         (rsp_character >= rdse_pkg::CHAR_A && rsp_character <= rdse_pkg::CHAR_F) ||
         (rsp_character == rdse_pkg::CHAR_POINT))
      else $error("illegal character emitted");

endmodule

bind radix_digit_string_emitter rdse_check u_rdse_check (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_character (rsp.character),
   .rsp_last      (rsp.last)
);
